// ===== design/ftda_pkg.sv =====
package ftda_pkg;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;
    localparam logic [3:0] FRAC_DIGITS_RESET = 4'd6;

    // digit-stack depth: 10 integer digits or 9 fraction digits
    localparam int STACK_DEPTH = 10;

    typedef struct packed {
        logic load;      // latch input, decode float
        logic mul_step;  // one shift-add step of fraction * 10^d
        logic mul_done;  // take quotient after shift
        logic dig_int;   // peel one digit off integer value
        logic dig_frac;  // peel one digit off fraction value
    } t_dp_cmd;

    typedef struct packed {
        logic err;        // input rejected
        logic mul_last;   // multiply counter at final step
        logic int_zero;   // remaining integer value is zero
        logic frac_full;  // all fraction digits peeled
        logic stack_one;  // one digit left on stack
        logic stack_empty;
    } t_dp_sts;

    // 10^d for d in 0..9, 30 bits
    function automatic logic [29:0] pow10(input logic [3:0] d);
        logic [29:0] r;
        unique case (d)
            4'd0: r = 30'd1;
            4'd1: r = 30'd10;
            4'd2: r = 30'd100;
            4'd3: r = 30'd1000;
            4'd4: r = 30'd10000;
            4'd5: r = 30'd100000;
            4'd6: r = 30'd1000000;
            4'd7: r = 30'd10000000;
            4'd8: r = 30'd100000000;
            default: r = 30'd1000000000;
        endcase
        return r;
    endfunction

endpackage

// ===== design/ftda_datapath.sv =====
module ftda_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_float_bits,
    input  logic [3:0]        i_digits,
    input  ftda_pkg::t_dp_cmd i_cmd,
    input  logic              i_pop,
    output ftda_pkg::t_dp_sts o_sts,
    output logic [3:0]        o_top_digit
);

    localparam int STACK_DEPTH_L = ftda_pkg::STACK_DEPTH;

    logic [30:0] r_ipart, n_ipart;
    logic [23:0] r_fmant;
    logic [7:0]  r_shift;
    logic [29:0] r_mult;     // multiplier, shifts right
    logic [53:0] r_prod;
    logic [29:0] r_fval, n_fval;
    logic        r_err;
    logic [4:0]  r_mcnt;
    logic [3:0]  r_fcnt;
    logic [3:0]  r_sp;
    logic [3:0]  r_stack [STACK_DEPTH_L];

    // float decode
    logic        sg;
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [23:0] mant;
    logic [7:0]  sh;
    logic [54:0] wide;
    logic        bad;

    always_comb begin
        sg   = i_float_bits[31];
        ex   = i_float_bits[30:23];
        fr   = i_float_bits[22:0];
        bad  = (ex == 8'hFF) || (sg && i_float_bits[30:0] != 31'd0) || (ex >= 8'd158);
        mant = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
        sh   = (ex == 8'd0) ? 8'd149 : ((ex >= 8'd150) ? 8'd0 : 8'd150 - ex);
        wide = {31'd0, mant} << ((ex >= 8'd150) ? ex - 8'd150 : 8'd0);
    end

    // digit peel: divide by ten via reciprocal multiply, exact for any 32-bit value;
    // integer and fraction peels never overlap, so they share it
    logic [31:0] dv_in;
    logic [63:0] dv_prod;
    logic [28:0] dv_q;
    logic [31:0] dv_q10;
    logic [3:0]  dv_rem;
    assign dv_in   = i_cmd.dig_frac ? {2'd0, r_fval} : {1'b0, r_ipart};
    assign dv_prod = dv_in * 32'hCCCCCCCD;
    assign dv_q    = dv_prod[63:35];
    assign dv_q10  = {dv_q, 3'd0} + {2'd0, dv_q, 1'b0};
    assign dv_rem  = dv_in[3:0] - dv_q10[3:0];

    logic [53:0] sumv;
    logic [53:0] shifted;
    assign sumv    = r_prod + (r_mult[0] ? ({30'd0, r_fmant} << r_mcnt) : 54'd0);
    assign shifted = (r_shift >= 8'd64) ? 54'd0 : (r_prod >> r_shift[5:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_err  <= 1'b0;
            r_mcnt <= '0;
            r_fcnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_err  <= bad;
                r_mcnt <= '0;
                r_fcnt <= '0;
                r_sp   <= '0;
            end
            if (i_cmd.mul_step) r_mcnt <= r_mcnt + 5'd1;
            if (i_cmd.dig_int || i_cmd.dig_frac) r_sp <= r_sp + 4'd1;
            else if (i_pop) r_sp <= r_sp - 4'd1;
            if (i_cmd.dig_frac) r_fcnt <= r_fcnt + 4'd1;
            if (i_cmd.mul_done) r_sp <= '0;
        end
    end

    always_comb begin
        n_ipart = r_ipart;
        n_fval  = r_fval;
        if (i_cmd.dig_int)  n_ipart = {2'd0, dv_q};
        if (i_cmd.dig_frac) n_fval  = {1'b0, dv_q};
        if (i_cmd.mul_done) n_fval  = 30'(shifted);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ipart <= (sh == 8'd0) ? wide[30:0] : 31'(mant >> sh);
            r_fmant <= (sh == 8'd0) ? 24'd0
                     : (sh >= 8'd24) ? mant : (mant & ((24'd1 << sh) - 24'd1));
            r_shift <= sh;
            r_mult  <= ftda_pkg::pow10(i_digits);
            r_prod  <= '0;
        end else begin
            r_ipart <= n_ipart;
            r_fval  <= n_fval;
            if (i_cmd.mul_step) begin
                r_prod <= sumv;
                r_mult <= r_mult >> 1;
            end
        end
        if (i_cmd.dig_int || i_cmd.dig_frac) r_stack[r_sp] <= dv_rem;
    end

    assign o_top_digit       = r_stack[r_sp - 4'd1];
    assign o_sts.err         = r_err;
    assign o_sts.mul_last    = (r_mcnt == 5'd29);
    assign o_sts.int_zero    = (r_ipart == 31'd0);
    assign o_sts.frac_full   = (r_fcnt == i_digits);
    assign o_sts.stack_one   = (r_sp == 4'd1);
    assign o_sts.stack_empty = (r_sp == 4'd0);

endmodule

// ===== design/ftda_ctrl.sv =====
module ftda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [3:0]        i_digits,
    input  ftda_pkg::t_dp_sts i_sts,
    output ftda_pkg::t_dp_cmd o_cmd,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_emit,
    output logic              o_dot,
    output logic              o_last,
    output logic              o_error
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_IDIG  = 8'b0000_0100,
        S_IOUT  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_FDIG  = 8'b0010_0000,
        S_DOT   = 8'b0100_0000,
        S_FOUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_pop   = 1'b0;
        o_emit  = 1'b0;
        o_dot   = 1'b0;
        o_last  = 1'b0;
        o_error = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.err) begin
                    o_emit = 1'b1; o_last = 1'b1; o_error = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.dig_int = 1'b1;
                    n_state = S_IDIG;
                end
            end
            S_IDIG: begin
                if (i_sts.int_zero) n_state = S_IOUT;
                else o_cmd.dig_int = 1'b1;
            end
            S_IOUT: begin
                o_emit = 1'b1;
                o_pop  = 1'b1;
                if (i_sts.stack_one) begin
                    if (i_digits == 4'd0) begin
                        o_last  = 1'b1;
                        n_state = S_IDLE;
                    end else n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                o_cmd.mul_done = 1'b1;
                o_emit = 1'b1;
                o_dot  = 1'b1;
                n_state = S_FDIG;
            end
            S_FDIG: begin
                if (i_sts.frac_full) n_state = S_FOUT;
                else o_cmd.dig_frac = 1'b1;
            end
            S_FOUT: begin
                o_emit = 1'b1;
                o_pop  = 1'b1;
                if (i_sts.stack_one) begin
                    o_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> o_busy) else $error("emit while idle");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_sts.stack_empty) else $error("pop on empty stack");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_last) |=> !o_busy) else $error("last beat not final");

endmodule

// ===== design/float_to_decimal_ascii.sv =====
// An error gives its single beat in the cycle after the accepting edge. A conversion peels
// one digit per cycle and emits one beat per cycle, with a 30-step shift-add multiply by 10^d
// between the integer and fraction digits; with no fraction the multiply is skipped.
// One item at a time: busy is high from the accepting edge until after the last beat.
// Beats cannot be stalled by the receiver. Synchronous active-low reset; frac_digits resets to 6.
module float_to_decimal_ascii #(
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_float_bits,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_frac_digits,
    output logic        o_valid,
    output logic [7:0]  o_char_code,
    output logic        o_last,
    output logic        o_error
);

    logic [3:0] r_frac_digits;
    logic [3:0] digits;
    ftda_pkg::t_dp_cmd cmd;
    ftda_pkg::t_dp_sts sts;
    logic pop, emit, dot, last, err;
    logic [3:0] top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_frac_digits <= ftda_pkg::FRAC_DIGITS_RESET;
        else if (i_cfg_we) r_frac_digits <= i_cfg_frac_digits;
    end

    assign digits = (r_frac_digits > 4'(MAX_FRAC_DIGITS)) ? 4'(MAX_FRAC_DIGITS)
                                                           : r_frac_digits;

    ftda_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_digits(digits),
        .i_sts(sts), .o_cmd(cmd), .o_pop(pop), .o_busy(busy), .o_emit(emit),
        .o_dot(dot), .o_last(last), .o_error(err)
    );

    ftda_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_float_bits(i_float_bits),
        .i_digits(digits), .i_cmd(cmd), .i_pop(pop), .o_sts(sts), .o_top_digit(top)
    );

    assign o_valid     = emit;
    assign o_char_code = err ? 8'd0 : (dot ? ftda_pkg::ASCII_DOT
                                           : ftda_pkg::ASCII_ZERO + {4'd0, top});
    assign o_last      = last;
    assign o_error     = err;

endmodule

// ===== tb/sv/tb_float_to_decimal_ascii.sv =====
module tb_float_to_decimal_ascii;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_float_bits;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_frac_digits;
    logic        o_valid;
    logic [7:0]  o_char_code;
    logic        o_last;
    logic        o_error;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       err;
    } t_char;

    localparam int MAX_DIGITS = 9;
    localparam int WATCHDOG   = 5000;

    t_char      char_q[$];
    logic [3:0] digits_cfg;
    int         n_fail;
    int         n_items;
    int         n_chars;
    int         n_errs;
    int         idle_cycles;

    float_to_decimal_ascii u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_float_bits      (i_float_bits),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_frac_digits (i_cfg_frac_digits),
        .o_valid           (o_valid),
        .o_char_code       (o_char_code),
        .o_last            (o_last),
        .o_error           (o_error)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // expected text for one float under the current digit count
    task automatic predict_text(input logic [31:0] bits);
        logic [7:0]  expo;
        logic [63:0] mant, ipart, fmant, fval, p10;
        int          rsh, d, n;
        logic [3:0]  digs[12];
        t_char       c;
        begin
            expo = bits[30:23];
            if (expo == 8'hFF || (bits[31] && bits[30:0] != 0) || expo >= 8'd158) begin
                c = '{code: 8'd0, last: 1'b1, err: 1'b1};
                char_q.push_back(c);
                return;
            end
            if (expo == 0) begin
                mant = {41'd0, bits[22:0]};
                rsh = 149;
            end else begin
                mant = {40'd0, 1'b1, bits[22:0]};
                rsh = (expo >= 150) ? 0 : 150 - expo;
            end
            if (rsh == 0) begin
                ipart = mant << (expo - 150);
                fmant = 0;
            end else if (rsh < 64) begin
                ipart = mant >> rsh;
                fmant = mant & ((64'd1 << rsh) - 1);
            end else begin
                ipart = 0;
                fmant = mant;
            end
            d = (digits_cfg > MAX_DIGITS) ? MAX_DIGITS : digits_cfg;
            p10 = 1;
            for (int i = 0; i < d; i++) p10 = p10 * 10;
            fval = (rsh == 0 || rsh >= 64) ? 64'd0 : (fmant * p10) >> rsh;
            n = 0;
            do begin
                digs[n] = 4'(ipart % 64'd10);
                ipart = ipart / 10;
                n++;
            end while (ipart != 0);
            for (int i = n; i > 0; i--) begin
                c = '{code: ftda_pkg::ASCII_ZERO + digs[i-1], last: (d == 0 && i == 1),
                      err: 1'b0};
                char_q.push_back(c);
            end
            if (d != 0) begin
                c = '{code: ftda_pkg::ASCII_DOT, last: 1'b0, err: 1'b0};
                char_q.push_back(c);
                for (int i = 0; i < d; i++) begin
                    digs[i] = 4'(fval % 64'd10);
                    fval = fval / 10;
                end
                for (int i = d; i > 0; i--) begin
                    c = '{code: ftda_pkg::ASCII_ZERO + digs[i-1], last: (i == 1), err: 1'b0};
                    char_q.push_back(c);
                end
            end
        end
    endtask

    // one float: random gap, then hold start until accepted
    task automatic send_float(input logic [31:0] bits);
        int gap;
        begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) gap = 0;
            @(negedge i_clk);
            repeat (gap) @(negedge i_clk);
            i_float_bits <= bits;
            start <= 1'b1;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            predict_text(bits);
            n_items++;
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain();
        while (char_q.size() != 0) @(posedge i_clk);
        // block is idle once the last beat is out; let it settle
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_digits(input logic [3:0] val);
        begin
            drain();
            i_cfg_frac_digits <= val;
            i_cfg_we <= 1'b1;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            digits_cfg = val;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_char got, exp_c;
            got = '{code: o_char_code, last: o_last, err: o_error};
            n_chars++;
            if (o_error) n_errs++;
            if (char_q.size() == 0) begin
                $display("%0t: unexpected beat, actual %h/%b/%b", $time,
                         o_char_code, o_last, o_error);
                n_fail++;
            end else begin
                exp_c = char_q.pop_front();
                if (got !== exp_c) begin
                    $display("%0t: mismatch, expected %h/%b/%b actual %h/%b/%b", $time,
                             exp_c.code, exp_c.last, exp_c.err, o_char_code, o_last, o_error);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        begin
            send_float(32'h00000000);  // zero
            send_float(32'h80000000);  // negative zero
            send_float(32'h3F800000);  // 1.0
            send_float(32'h3FC00000);  // 1.5
            send_float(32'h3DCCCCCD);  // 0.1
            send_float(32'h00000001);  // smallest subnormal
            send_float(32'h007FFFFF);  // largest subnormal
            send_float(32'h00800000);  // smallest normal
            send_float(32'h4B7FFFFF);  // 2^24 - 1: integer, no fraction bit
            send_float(32'h4B800000);
            send_float(32'h4EFFFFFF);  // largest in range
            send_float(32'h4F000000);  // 2^31: too large
            send_float(32'h7F7FFFFF);
            send_float(32'h7F800000);  // infinity
            send_float(32'h7FC00001);  // NaN
            send_float(32'hFFFFFFFF);
            send_float(32'hBF800000);  // negative
            send_float(32'h80000001);  // negative subnormal
            send_float(32'h3F7FFFFF);  // just under one
            send_float(32'h461C3FFF);
        end
    endtask

    task automatic test_digit_counts();
        logic [3:0] vals[5] = '{4'd0, 4'd9, 4'd15, 4'd1, 4'd10};
        begin
            foreach (vals[i]) begin
                write_digits(vals[i]);
                send_float(32'h3FC00000);
                send_float(32'h4EFFFFFF);
                send_float(32'h00000001);
            end
        end
    endtask

    task automatic test_random();
        logic [31:0] bits;
        begin
            for (int ph = 0; ph < 4; ph++) begin
                write_digits(4'($urandom_range(0, 15)));
                for (int i = 0; i < 25; i++) begin
                    bits = $urandom;
                    case ($urandom_range(0, 3))
                        0: bits[30:23] = 8'($urandom_range(118, 157));
                        1: bits = {1'b0, 8'($urandom_range(118, 157)), bits[22:0]};
                        2: bits[31] = 1'b0;
                        default: ;
                    endcase
                    send_float(bits);
                end
            end
        end
    endtask

    initial begin
        n_fail = 0;
        n_items = 0;
        n_chars = 0;
        n_errs = 0;
        idle_cycles = 0;
        digits_cfg = ftda_pkg::FRAC_DIGITS_RESET;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_float_bits = '0;
        i_cfg_we = 1'b0;
        i_cfg_frac_digits = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_digit_counts();
        test_random();
        write_digits(4'd6);
        send_float(32'h40490FDB);
        drain();
        $display("Converted %0d floats into %0d characters (%0d error beats),",
                 n_items, n_chars, n_errs);
        $display("digit counts 0, 1, 6, 9 and saturated values above 9.");
        if (n_fail == 0 && char_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
